>>> hdl/cell_parameter_text_parser_top_defines.svh
// assertion macros for the checker in cpp_checker.sv
`ifndef CELL_PARAMETER_TEXT_PARSER_TOP_DEFINES_SVH
`define CELL_PARAMETER_TEXT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk and held off while rst_n is low
`define CPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cell parameter parser check failed");

// next-cycle implication, clocked on clk and held off while rst_n is low
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cell parameter parser check failed");

`endif

>>> hdl/cpp_pkg.sv
`default_nettype none

package cpp_pkg;

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int TARGET_W = 3;
  localparam int VALUE_W  = 37;

  typedef logic [VALUE_W-1:0] value_t;

  // one character item handed to the parser
  typedef struct packed {
    logic              fire;
    logic [CHAR_W-1:0] char_code;
    logic              eof;
  } step_t;

  // result produced by the parser for the current item
  typedef struct packed {
    logic                valid;
    logic [TARGET_W-1:0] which_param;
    value_t              value_micro;
    logic                had_digit;
    logic                saturated;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/cell_parameter_text_parser_top.sv
// Cell parameter text parser: takes one text byte per item (in_tuser set marks end of
// file) and emits one item each time the number after a _cell_length_a/b/c or
// _cell_angle_alpha/beta/gamma keyword ends, as the value times 10^FRAC_DIGITS with the
// integer part clamped at INT_DIGITS nines. Throughput is one item per clock while the out
// channel is not stalled. A result is offered on the out channel once its closing character
// has passed through the input register and the per-character parser step has loaded the
// result register. The parser step is a small state machine plus a times-ten accumulate,
// done combinationally ahead of the result register.
`default_nettype none

module cell_parameter_text_parser_top #(
  parameter int FRAC_DIGITS = 6,
  parameter int INT_DIGITS  = 5
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // char_code[7:0]
  input  wire         in_tuser,   // end_of_file
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // value_micro[36:0], zero fill[39:37]
  output logic [4:0]  out_tuser   // which_param[2:0], had_digit[3], saturated[4]
);
  import cpp_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_char_r;
  logic        in_eof_r;
  logic        fire;
  step_t       step;
  result_t     result;

  logic                out_valid_r;
  logic [TARGET_W-1:0] out_which_r;
  value_t              out_value_r;
  logic                out_had_r;
  logic                out_sat_r;

  // the parser steps when the result register can take whatever it produces
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_eof_r  <= in_tuser;
    end
  end

  assign step.fire      = fire;
  assign step.char_code = in_char_r;
  assign step.eof       = in_eof_r;

  cpp_parser #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .INT_DIGITS  (INT_DIGITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= result.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.valid) begin
      out_which_r <= result.which_param;
      out_value_r <= result.value_micro;
      out_had_r   <= result.had_digit;
      out_sat_r   <= result.saturated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_value_r};
  assign out_tuser  = {out_sat_r, out_had_r, out_which_r};

endmodule

`default_nettype wire

>>> hdl/cpp_parser.sv
`default_nettype none

module cpp_parser #(
  parameter int FRAC_DIGITS = 6,
  parameter int INT_DIGITS  = 5
) (
  input  wire              clk,
  input  wire              rst_n,
  input  cpp_pkg::step_t   step_i,
  output cpp_pkg::result_t result_o
);
  import cpp_pkg::*;

  // parser states
  typedef enum logic [7:0] {
    S_WAIT   = 8'b0000_0001,
    S_NEW    = 8'b0000_0010,
    S_MATCH  = 8'b0000_0100,
    S_SKIP   = 8'b0000_1000,
    S_CELL   = 8'b0001_0000,
    S_LENGTH = 8'b0010_0000,
    S_ANGLE  = 8'b0100_0000,
    S_NUMBER = 8'b1000_0000
  } state_t;

  typedef value_t weight_tab_t [16];

  // keyword words, sharing codes with the parameter targets
  localparam logic [2:0] W_ELL   = 3'd0;
  localparam logic [2:0] W_ENGTH = 3'd1;
  localparam logic [2:0] W_NGLE  = 3'd2;
  localparam logic [2:0] W_LPHA  = 3'd3;
  localparam logic [2:0] W_ETA   = 3'd4;
  localparam logic [2:0] W_AMMA  = 3'd5;

  localparam logic [2:0] T_A     = 3'd0;
  localparam logic [2:0] T_B     = 3'd1;
  localparam logic [2:0] T_C     = 3'd2;

  // characters
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < 19; i++) begin
      if (i < n) v = v * 64'd10;
    end
    return v;
  endfunction

  // weight of each fraction digit position, zero past the last one
  function automatic weight_tab_t weight_table();
    weight_tab_t t;
    logic [63:0] p;
    for (int i = 0; i < 16; i++) begin
      p = pow10(FRAC_DIGITS - 1 - i);
      t[i] = (i < FRAC_DIGITS) ? p[VALUE_W-1:0] : '0;
    end
    return t;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] w);
    logic [2:0] n;
    case (w)
      W_ELL:   n = 3'd3;
      W_ENGTH: n = 3'd5;
      W_NGLE:  n = 3'd4;
      W_LPHA:  n = 3'd4;
      W_ETA:   n = 3'd3;
      W_AMMA:  n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      W_ELL: begin
        case (i)
          3'd0:    c = CH_E;
          default: c = CH_L;
        endcase
      end
      W_ENGTH: begin
        case (i)
          3'd0:    c = CH_E;
          3'd1:    c = CH_N;
          3'd2:    c = CH_G;
          3'd3:    c = CH_T;
          default: c = CH_H;
        endcase
      end
      W_NGLE: begin
        case (i)
          3'd0:    c = CH_N;
          3'd1:    c = CH_G;
          3'd2:    c = CH_L;
          default: c = CH_E;
        endcase
      end
      W_LPHA: begin
        case (i)
          3'd0:    c = CH_L;
          3'd1:    c = CH_P;
          3'd2:    c = CH_H;
          default: c = CH_A;
        endcase
      end
      W_ETA: begin
        case (i)
          3'd0:    c = CH_E;
          3'd1:    c = CH_T;
          default: c = CH_A;
        endcase
      end
      W_AMMA: begin
        case (i)
          3'd0:    c = CH_A;
          3'd1:    c = CH_M;
          3'd2:    c = CH_M;
          default: c = CH_A;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  localparam int          LIMIT       = 10**INT_DIGITS - 1;
  localparam int          IW          = $clog2(LIMIT + 1);
  localparam logic [63:0] SCALE64     = pow10(FRAC_DIGITS);
  localparam logic [63:0] SAT64       = 64'(LIMIT) * SCALE64;
  localparam value_t      SCALE       = SCALE64[VALUE_W-1:0];
  localparam value_t      SAT_VALUE   = SAT64[VALUE_W-1:0];
  localparam weight_tab_t FRAC_WEIGHT = weight_table();

  state_t      state_r,       state_nxt;
  logic [2:0]  word_index_r,  word_index_nxt;
  logic [2:0]  pending_r,     pending_nxt;
  value_t      value_r,       value_nxt;
  logic [IW-1:0] int_r,       int_nxt;
  logic [3:0]  frac_count_r,  frac_count_nxt;
  logic        seen_point_r,  seen_point_nxt;
  logic        seen_digit_r,  seen_digit_nxt;
  logic        sat_r,         sat_nxt;

  logic [7:0]    ch;
  logic [7:0]    ch_off;
  logic [3:0]    digit;
  logic          is_digit;
  logic [IW+3:0] int_ext;
  logic [IW+3:0] int_tent;
  logic          int_over;
  value_t        value_int;
  value_t        value_frac;
  logic [2:0]    index_inc;
  logic          start_number;
  logic [2:0]    start_target;
  logic          emit;

  // digit decode
  assign ch       = step_i.char_code;
  assign ch_off   = ch - CH_ZERO;
  assign digit    = ch_off[3:0];
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  // integer part: times ten plus digit, with saturation test
  assign int_ext   = {4'b0000, int_r};
  assign int_tent  = (int_ext << 3) + (int_ext << 1) + {{IW{1'b0}}, digit};
  assign int_over  = sat_r || (int_tent > (IW+4)'(LIMIT));
  assign value_int = (value_r << 3) + (value_r << 1) + value_t'(digit) * SCALE;

  // fraction part: add the digit at its position weight
  assign value_frac = value_r + value_t'(digit) * FRAC_WEIGHT[frac_count_r];

  assign index_inc = word_index_r + 3'd1;

  // next state for one character
  always_comb begin
    state_nxt      = state_r;
    word_index_nxt = word_index_r;
    pending_nxt    = pending_r;
    value_nxt      = value_r;
    int_nxt        = int_r;
    frac_count_nxt = frac_count_r;
    seen_point_nxt = seen_point_r;
    seen_digit_nxt = seen_digit_r;
    sat_nxt        = sat_r;
    start_number   = 1'b0;
    start_target   = pending_r;
    emit           = 1'b0;

    if (step_i.eof) begin
      emit           = (state_r == S_NUMBER);
      state_nxt      = S_WAIT;
      word_index_nxt = '0;
      pending_nxt    = '0;
      value_nxt      = '0;
      int_nxt        = '0;
      frac_count_nxt = '0;
      seen_point_nxt = 1'b0;
      seen_digit_nxt = 1'b0;
      sat_nxt        = 1'b0;
    end else begin
      unique case (state_r)
        S_NEW: begin
          if (ch == CH_C) begin
            pending_nxt    = W_ELL;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_UNDER) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_WAIT;
          end
        end
        S_MATCH: begin
          if (ch == CH_UNDER) begin
            state_nxt = S_NEW;
          end else if (pending_r > W_AMMA || word_index_r >= word_len(pending_r)) begin
            state_nxt = S_WAIT;
          end else if (ch == word_char(pending_r, word_index_r)) begin
            word_index_nxt = index_inc;
            if (index_inc >= word_len(pending_r)) begin
              if (pending_r < W_LPHA) state_nxt = S_SKIP;
              else start_number = 1'b1;
            end
          end else begin
            state_nxt = S_WAIT;
          end
        end
        S_SKIP: begin
          if (ch == CH_UNDER) begin
            case (pending_r)
              W_ELL:   state_nxt = S_CELL;
              W_ENGTH: state_nxt = S_LENGTH;
              W_NGLE:  state_nxt = S_ANGLE;
              default: state_nxt = S_NEW;
            endcase
          end
        end
        S_CELL: begin
          if (ch == CH_L) begin
            pending_nxt    = W_ENGTH;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_A) begin
            pending_nxt    = W_NGLE;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_UNDER) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_WAIT;
          end
        end
        S_LENGTH: begin
          if (ch == CH_A) begin
            start_number = 1'b1;
            start_target = T_A;
          end else if (ch == CH_B) begin
            start_number = 1'b1;
            start_target = T_B;
          end else if (ch == CH_C) begin
            start_number = 1'b1;
            start_target = T_C;
          end else if (ch == CH_UNDER) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_WAIT;
          end
        end
        S_ANGLE: begin
          if (ch == CH_A) begin
            pending_nxt    = W_LPHA;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_B) begin
            pending_nxt    = W_ETA;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_G) begin
            pending_nxt    = W_AMMA;
            word_index_nxt = '0;
            state_nxt      = S_MATCH;
          end else if (ch == CH_UNDER) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_WAIT;
          end
        end
        S_NUMBER: begin
          if (ch == CH_UNDER) begin
            emit      = 1'b1;
            state_nxt = S_NEW;
          end else if (ch == CH_POINT) begin
            if (!seen_point_r) begin
              seen_point_nxt = 1'b1;
            end else begin
              emit      = 1'b1;
              state_nxt = S_WAIT;
            end
          end else if (is_digit) begin
            seen_digit_nxt = 1'b1;
            if (!seen_point_r) begin
              if (int_over) begin
                int_nxt   = IW'(LIMIT);
                value_nxt = SAT_VALUE;
                sat_nxt   = 1'b1;
              end else begin
                int_nxt   = int_tent[IW-1:0];
                value_nxt = value_int;
              end
            end else if (frac_count_r < 4'(FRAC_DIGITS)) begin
              value_nxt      = value_frac;
              frac_count_nxt = frac_count_r + 4'd1;
            end
          end else if (seen_digit_r) begin
            emit      = 1'b1;
            state_nxt = S_WAIT;
          end
        end
        default: begin
          if (ch == CH_UNDER) state_nxt = S_NEW;
          else state_nxt = S_WAIT;
        end
      endcase

      // clear the number accumulator for a new parameter
      if (start_number) begin
        pending_nxt    = start_target;
        value_nxt      = '0;
        int_nxt        = '0;
        frac_count_nxt = '0;
        seen_point_nxt = 1'b0;
        seen_digit_nxt = 1'b0;
        sat_nxt        = 1'b0;
        state_nxt      = S_NUMBER;
      end
    end
  end

  // result for the current character
  always_comb begin
    result_o.valid       = step_i.fire && emit;
    result_o.which_param = pending_r;
    result_o.value_micro = value_r;
    result_o.had_digit   = seen_digit_r;
    result_o.saturated   = sat_r;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WAIT;
      word_index_r <= '0;
      pending_r    <= '0;
      value_r      <= '0;
      int_r        <= '0;
      frac_count_r <= '0;
      seen_point_r <= 1'b0;
      seen_digit_r <= 1'b0;
      sat_r        <= 1'b0;
    end else if (step_i.fire) begin
      state_r      <= state_nxt;
      word_index_r <= word_index_nxt;
      pending_r    <= pending_nxt;
      value_r      <= value_nxt;
      int_r        <= int_nxt;
      frac_count_r <= frac_count_nxt;
      seen_point_r <= seen_point_nxt;
      seen_digit_r <= seen_digit_nxt;
      sat_r        <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cpp_checker.sv
`default_nettype none
`include "cell_parameter_text_parser_top_defines.svh"

module cpp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [7:0]  in_tdata,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire [4:0]  out_tuser
);

  // a stalled result stays offered
  `CPP_ASSERT_NEXT(a_out_hold_valid, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its payload
  `CPP_ASSERT_NEXT(a_out_hold_data, out_tvalid && !out_tready,
                   $stable(out_tdata) && $stable(out_tuser))

  // input stalls only behind a result that is not being taken
  `CPP_ASSERT_SAME(a_in_stall_cause, !in_tready, out_tvalid && !out_tready)

  // a number without digits is zero and never clamped
  `CPP_ASSERT_SAME(a_no_digit_zero, out_tvalid && !out_tuser[3],
                   out_tdata == 40'd0 && !out_tuser[4])

endmodule

bind cell_parameter_text_parser_top cpp_checker u_checker (.*);

`default_nettype wire

>>> bench/cell_parameter_reading_checker.sv
`timescale 1ns / 1ps

module cell_parameter_reading_checker #(
  parameter int FRAC_DIGITS = 6,
  parameter int INT_DIGITS  = 5
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  input  wire                         in_tready,
  input  wire  [cpp_pkg::CHAR_W-1:0]  in_tdata,
  input  wire                         in_tuser,
  input  wire                         out_tvalid,
  input  wire                         out_tready,
  input  wire  [39:0]                 out_tdata,
  input  wire  [4:0]                  out_tuser,
  input  wire                         drain_done,
  output int                          mismatches,
  output int                          readings_pending
);
  import cpp_pkg::*;

  // parser phases, keyword fragments and parameter targets
  typedef enum logic [3:0] {
    P_WAIT, P_NEW, P_MATCH, P_SKIP, P_CELL, P_LENGTH, P_ANGLE, P_NUMBER
  } parse_phase_e;

  typedef enum logic [2:0] {
    W_ELL, W_ENGTH, W_NGLE, W_LPHA, W_ETA, W_AMMA
  } word_e;

  typedef enum logic [TARGET_W-1:0] {
    TGT_A, TGT_B, TGT_C, TGT_ALPHA, TGT_BETA, TGT_GAMMA
  } target_e;

  typedef struct packed {
    logic [TARGET_W-1:0] which_param;
    value_t              value_micro;
    logic                had_digit;
    logic                saturated;
  } reading_t;

  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_POINT      = ".";
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_NINE       = 8'd57;

  function automatic longint unsigned ten_to(int n);
    longint unsigned v;
    v = 1;
    for (int i = 0; i < n; i++) v = v * 10;
    return v;
  endfunction

  localparam longint unsigned FRAC_SCALE = ten_to(FRAC_DIGITS);
  localparam longint unsigned INT_LIMIT  = ten_to(INT_DIGITS) - 1;

  // predicted parser state
  parse_phase_e    phase;
  word_e           word;
  int              word_pos;
  target_e         target;
  longint unsigned acc;
  int              frac_n;
  logic            point_seen;
  logic            digit_seen;
  logic            clamped;

  reading_t        readings_due[$];
  int              fail_tally    = 0;
  logic            drain_checked = 1'b0;

  function automatic int word_len(word_e w);
    case (w)
      W_ELL, W_ETA: return 3;
      W_ENGTH:      return 5;
      default:      return 4;
    endcase
  endfunction

  function automatic logic [7:0] word_char(word_e w, int i);
    logic [39:0] txt;
    case (w)
      W_ELL:   txt = "ell";
      W_ENGTH: txt = "ength";
      W_NGLE:  txt = "ngle";
      W_LPHA:  txt = "lpha";
      W_ETA:   txt = "eta";
      default: txt = "amma";
    endcase
    return txt[8*(word_len(w)-1-i) +: 8];
  endfunction

  task automatic reset_parser();
    phase      = P_WAIT;
    word       = W_ELL;
    word_pos   = 0;
    target     = TGT_A;
    acc        = 0;
    frac_n     = 0;
    point_seen = 1'b0;
    digit_seen = 1'b0;
    clamped    = 1'b0;
  endtask

  task automatic start_word(word_e w);
    word     = w;
    word_pos = 0;
    phase    = P_MATCH;
  endtask

  task automatic start_number(target_e t);
    target     = t;
    acc        = 0;
    frac_n     = 0;
    point_seen = 1'b0;
    digit_seen = 1'b0;
    clamped    = 1'b0;
    phase      = P_NUMBER;
  endtask

  function automatic reading_t current_reading();
    reading_t r;
    r.which_param = target;
    r.value_micro = acc[VALUE_W-1:0];
    r.had_digit   = digit_seen;
    r.saturated   = clamped;
    return r;
  endfunction

  // integer digits clamp at the limit, fraction digits past the scale drop out
  task automatic add_digit(int d);
    longint unsigned ip;
    digit_seen = 1'b1;
    if (!point_seen) begin
      ip = acc / FRAC_SCALE;
      if (clamped || ip > (INT_LIMIT - d) / 10) begin
        ip      = INT_LIMIT;
        clamped = 1'b1;
      end else begin
        ip = ip * 10 + d;
      end
      acc = ip * FRAC_SCALE;
    end else if (frac_n < FRAC_DIGITS) begin
      acc    = acc + d * ten_to(FRAC_DIGITS - 1 - frac_n);
      frac_n = frac_n + 1;
    end
  endtask

  // one character step of the keyword walk and number reader
  task automatic advance_parser(input logic [7:0] ch, input logic eof,
                                output logic fresh, output reading_t r);
    fresh = 1'b0;
    r     = '0;
    if (eof) begin
      if (phase == P_NUMBER) begin
        fresh = 1'b1;
        r     = current_reading();
      end
      reset_parser();
    end else begin
      case (phase)
        P_NEW: begin
          if (ch == "c") start_word(W_ELL);
          else if (ch == CH_UNDERSCORE) phase = P_NEW;
          else phase = P_WAIT;
        end
        P_MATCH: begin
          if (ch == CH_UNDERSCORE) begin
            phase = P_NEW;
          end else if (ch == word_char(word, word_pos)) begin
            word_pos = word_pos + 1;
            if (word_pos >= word_len(word)) begin
              case (word)
                W_LPHA:  start_number(TGT_ALPHA);
                W_ETA:   start_number(TGT_BETA);
                W_AMMA:  start_number(TGT_GAMMA);
                default: phase = P_SKIP;
              endcase
            end
          end else begin
            phase = P_WAIT;
          end
        end
        P_SKIP: begin
          if (ch == CH_UNDERSCORE) begin
            case (word)
              W_ELL:   phase = P_CELL;
              W_ENGTH: phase = P_LENGTH;
              W_NGLE:  phase = P_ANGLE;
              default: phase = P_NEW;
            endcase
          end
        end
        P_CELL: begin
          if (ch == "l") start_word(W_ENGTH);
          else if (ch == "a") start_word(W_NGLE);
          else if (ch == CH_UNDERSCORE) phase = P_NEW;
          else phase = P_WAIT;
        end
        P_LENGTH: begin
          if (ch == "a") start_number(TGT_A);
          else if (ch == "b") start_number(TGT_B);
          else if (ch == "c") start_number(TGT_C);
          else if (ch == CH_UNDERSCORE) phase = P_NEW;
          else phase = P_WAIT;
        end
        P_ANGLE: begin
          if (ch == "a") start_word(W_LPHA);
          else if (ch == "b") start_word(W_ETA);
          else if (ch == "g") start_word(W_AMMA);
          else if (ch == CH_UNDERSCORE) phase = P_NEW;
          else phase = P_WAIT;
        end
        P_NUMBER: begin
          if (ch == CH_UNDERSCORE) begin
            fresh = 1'b1;
            r     = current_reading();
            phase = P_NEW;
          end else if (ch == CH_POINT) begin
            if (!point_seen) begin
              point_seen = 1'b1;
            end else begin
              fresh = 1'b1;
              r     = current_reading();
              phase = P_WAIT;
            end
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            add_digit(ch - CH_ZERO);
          end else if (digit_seen) begin
            fresh = 1'b1;
            r     = current_reading();
            phase = P_WAIT;
          end
        end
        default: begin
          if (ch == CH_UNDERSCORE) phase = P_NEW;
          else phase = P_WAIT;
        end
      endcase
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_tally = fail_tally + 1;
    end
  endtask

  // compare results first, then predict from the item taken at this edge
  always @(posedge clk) begin : watch
    reading_t due;
    logic     fresh;
    if (!rst_n) begin
      reset_parser();
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected result item: tdata %h tuser %h", out_tdata, out_tuser);
          fail_tally = fail_tally + 1;
        end else begin
          due = readings_due.pop_front();
          check_field("which_param", due.which_param, out_tuser[2:0]);
          check_field("value_micro", due.value_micro, out_tdata[36:0]);
          check_field("had_digit", due.had_digit, out_tuser[3]);
          check_field("saturated", due.saturated, out_tuser[4]);
          check_field("tdata fill", 0, out_tdata[39:37]);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_parser(in_tdata, in_tuser, fresh, due);
        if (fresh) readings_due.push_back(due);
      end
      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (readings_due.size() != 0) begin
          $error("%0d expected result items never arrived", readings_due.size());
          fail_tally = fail_tally + readings_due.size();
        end
      end
    end
    mismatches       <= fail_tally;
    readings_pending <= readings_due.size();
  end

endmodule

>>> bench/cell_parameter_text_parser_top_tb.sv
`timescale 1ns / 1ps

module cell_parameter_text_parser_top_tb;

  localparam int  RANDOM_ITEMS = 680;
  localparam int  MIN_RECORDS  = 20;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  END_PAUSE    = 16;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        drain_done = 1'b0;
  int          mismatches;
  int          readings_pending;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          records_sent = 0;
  bit          in_calm = 1'b0;
  logic [7:0]  text_q[$];

  cell_parameter_text_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cell_parameter_reading_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .drain_done       (drain_done),
    .mismatches       (mismatches),
    .readings_pending (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cell_parameter_text_parser_top test failed");
      $finish;
    end
  end

  // result side: random stalls before each item, with calm stretches
  initial begin
    int stall;
    bit out_calm;
    out_calm = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // one character item, with an optional gap ahead of it
  task automatic send_item(input logic [7:0] ch, input logic eof);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic flush_text();
    while (text_q.size() != 0) send_item(text_q.pop_front(), 1'b0);
  endtask

  task automatic send_text(string s);
    queue_text(s);
    flush_text();
  endtask

  // hold the sender until every expected result has been taken
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
  endtask

  // keyword, optional junk in the skipped parts, then a number and a terminator
  task automatic send_random_record();
    int which;
    int n_int;
    int n_frac;
    int term;
    int spot;
    which = $urandom_range(0, 5);
    queue_text("_cell");
    if ($urandom_range(0, 7) == 0) queue_text("s-x");
    if (which < 3) begin
      queue_text("_length");
      if ($urandom_range(0, 7) == 0) queue_text("XZ");
      case (which)
        0:       queue_text("_a");
        1:       queue_text("_b");
        default: queue_text("_c");
      endcase
    end else begin
      queue_text("_angle");
      if ($urandom_range(0, 7) == 0) queue_text("s");
      case (which)
        3:       queue_text("_alpha");
        4:       queue_text("_beta");
        default: queue_text("_gamma");
      endcase
    end
    repeat ($urandom_range(0, 2)) queue_text($urandom_range(0, 1) ? " " : "=");
    n_int = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 8);
    repeat (n_int) text_q.push_back(8'd48 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) != 0) begin
      queue_text(".");
      n_frac = $urandom_range(0, 9);
      repeat (n_frac) text_q.push_back(8'd48 + 8'($urandom_range(0, 9)));
    end
    term = $urandom_range(0, 6);
    case (term)
      0: queue_text(" ");
      1: queue_text("\n");
      2: queue_text("_");
      3: queue_text(".");
      4: queue_text("(");
      5: queue_text("x");
      default: ;
    endcase
    // occasionally break one character anywhere in the record
    if ($urandom_range(0, 9) == 0) begin
      spot = $urandom_range(0, text_q.size() - 1);
      text_q[spot] = 8'($urandom_range(0, 255));
    end
    flush_text();
    if (term == 6) send_item(8'($urandom_range(0, 255)), 1'b1);
    records_sent++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  // stimulus and verdict
  initial begin
    int random_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, every parameter, each way a number ends
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_text("_cell_length_a 12.345");
    send_item("Z", 1'b1);
    send_text("_cell_length_b 123456.1234567_");
    send_text("cell_length_c 99999.999999 ");
    send_text("_cell_angle_alpha 90.0.5");
    send_text("_cel1_cell_angle_beta x=7\n");
    send_text("_cell_angle_gamma__cellXY_lengthQ_c .");
    send_item("_", 1'b1);
    send_item(8'hff, 1'b1);
    wait_for_drain();

    // random: mostly well-formed records, some noise and broken ones
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS || records_sent < MIN_RECORDS) begin
      if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_record();
      if ($urandom_range(0, 19) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (END_PAUSE) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("cell_parameter_text_parser_top test passed");
    end else begin
      $display("cell_parameter_text_parser_top test failed");
    end
    $finish;
  end

endmodule
